// ===== hw/rtl/pplc_pkg.sv =====
// Shared types, constants and tables of the pad port latch controller.
package pplc_pkg;

    localparam int NUM_PORTS   = 2;
    localparam int NUM_DEVICES = 8;
    localparam int TAP_SLOTS   = 4;
    localparam int DEV_AW      = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int SLOT_W      = 3;
    localparam int WORD_W      = 32;
    localparam int HALF_W      = 16;

    localparam logic [2:0]          TAP_LIMIT = 3'(TAP_SLOTS);
    localparam logic [SLOT_W:0]     DEV_LIMIT = (SLOT_W + 1)'(NUM_DEVICES);

    // Device slot picked by each tap position, per port.
    localparam logic [SLOT_W-1:0] SLOT_MAP [NUM_PORTS][4] = '{
        '{3'd0, 3'd2, 3'd3, 3'd4},
        '{3'd1, 3'd5, 3'd6, 3'd7}
    };

    localparam logic [1:0]        MULTITAP_RESET = 2'd0;
    localparam logic [3:0]        SIG_RESET      = 4'd14;
    localparam logic [10:0]       DELAY_RESET    = 11'd1536;
    localparam logic [HALF_W-1:0] STATUS_READY   = 16'h0008;

    // Address bit positions.
    localparam int ADDR_PORT = 7;
    localparam int ADDR_DEC  = 6;
    localparam int ADDR_HIGH = 1;
    localparam int ADDR_BYTE = 0;

    // Control bit positions.
    localparam int CTRL_TRIGGER = 0;
    localparam int CTRL_MODE    = 1;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TIME  = 2'd2,
        OP_LOAD  = 2'd3
    } op_t;

    localparam logic [1:0] CFG_MULTITAP = 2'd0;
    localparam logic [1:0] CFG_TAP_SIG  = 2'd1;
    localparam logic [1:0] CFG_DELAY    = 2'd2;

    typedef struct packed {
        op_t         op;
        logic [7:0]  address;
        logic        byte_access;
        logic [15:0] write_data;
        logic [15:0] elapsed;
        logic [2:0]  device_index;
        logic [31:0] device_word;
    } req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  multitap;
        logic [3:0]  tap_sig;
        logic [10:0] delay;
    } cfg_t;

    // Item info handed from the port stage to the result stage.
    typedef struct packed {
        logic                 is_read;
        logic                 is_status;
        logic                 status_set;
        logic                 rd_port;
        logic                 rd_high;
        logic                 byte_access;
        logic                 byte_hi;
        logic                 irq;
        logic [NUM_PORTS-1:0] latch;
        logic [NUM_PORTS-1:0] use_sig;
        logic [NUM_PORTS-1:0] slot_ok;
    } stage_t;

endpackage

// ===== hw/rtl/pplc_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
module pplc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hw/rtl/pplc_port_ctrl.sv =====
// Port stage: time advance, register access side effects and device table writes.
module pplc_port_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  pplc_pkg::req_t             req,
    input  pplc_pkg::cfg_t             cfg,
    output logic                       ram_we,
    output logic [pplc_pkg::DEV_AW-1:0] ram_waddr,
    output logic [pplc_pkg::WORD_W-1:0] ram_wdata,
    output logic [pplc_pkg::DEV_AW-1:0] ram_raddr0,
    output logic [pplc_pkg::DEV_AW-1:0] ram_raddr1,
    output pplc_pkg::stage_t           stage,
    output logic                       stage_valid
);

    localparam int NP = pplc_pkg::NUM_PORTS;

    logic [2:0]  ctrl_reg    [NP];
    logic [2:0]  ctrl_next   [NP];
    logic [2:0]  tap_reg     [NP];
    logic [2:0]  tap_next    [NP];
    logic [10:0] pend_reg    [NP];
    logic [10:0] pend_next   [NP];
    logic [NP-1:0] ready_reg;
    logic [NP-1:0] ready_next;
    logic        irq_reg;
    logic        irq_next;
    logic [pplc_pkg::NUM_DEVICES-1:0] dval_reg;
    logic [pplc_pkg::NUM_DEVICES-1:0] dval_next;

    logic [pplc_pkg::SLOT_W-1:0] slot [NP];
    pplc_pkg::stage_t            info;
    pplc_pkg::stage_t            stage_reg;
    logic                        stage_valid_reg;
    logic                        load_ok;

    assign load_ok = ({1'b0, req.device_index} < pplc_pkg::DEV_LIMIT);

    always_comb
    begin
        logic       port;
        logic [2:0] v;

        ctrl_next  = ctrl_reg;
        tap_next   = tap_reg;
        pend_next  = pend_reg;
        ready_next = ready_reg;
        irq_next   = irq_reg;
        dval_next  = dval_reg;
        info       = '0;
        port       = 1'b0;
        v          = 3'd0;

        // Advance time, port 0 first.
        for (int p = 0; p < NP; p++)
        begin
            slot[p] = '0;
            if (pend_reg[p] != 11'd0)
            begin
                if ({5'd0, pend_reg[p]} > req.elapsed)
                begin
                    pend_next[p] = pend_reg[p] - req.elapsed[10:0];
                end
                else
                begin
                    pend_next[p]  = 11'd0;
                    info.latch[p] = 1'b1;
                    if (cfg.multitap[p])
                    begin
                        if (tap_reg[p] >= pplc_pkg::TAP_LIMIT)
                        begin
                            info.use_sig[p] = 1'b1;
                        end
                        else
                        begin
                            slot[p]     = pplc_pkg::SLOT_MAP[p][tap_reg[p][1:0]];
                            tap_next[p] = tap_reg[p] + 3'd1;
                        end
                    end
                    else
                    begin
                        slot[p] = pplc_pkg::SLOT_W'(p);
                    end
                    ready_next[p] = 1'b1;
                    ctrl_next[p][pplc_pkg::CTRL_TRIGGER] = 1'b0;
                    irq_next = 1'b1;
                end
            end
            info.slot_ok[p] = ({1'b0, slot[p]} < pplc_pkg::DEV_LIMIT)
                            && dval_reg[slot[p][pplc_pkg::DEV_AW-1:0]];
        end

        // Then the access itself.
        case (req.op)
            pplc_pkg::OP_READ:
            begin
                port             = req.address[pplc_pkg::ADDR_PORT];
                info.is_read     = 1'b1;
                info.rd_port     = port;
                info.rd_high     = req.address[pplc_pkg::ADDR_HIGH];
                info.byte_access = req.byte_access;
                info.byte_hi     = req.address[pplc_pkg::ADDR_BYTE];
                info.is_status   = !req.address[pplc_pkg::ADDR_DEC]
                                && !req.address[pplc_pkg::ADDR_HIGH];
                info.status_set  = ready_next[port];
                if (!info.is_status && !req.address[pplc_pkg::ADDR_HIGH])
                begin
                    ready_next[port] = 1'b0;
                end
                if (ready_next == '0)
                begin
                    irq_next = 1'b0;
                end
            end
            pplc_pkg::OP_WRITE:
            begin
                if (!req.address[pplc_pkg::ADDR_DEC])
                begin
                    port = req.address[pplc_pkg::ADDR_PORT];
                    v    = req.write_data[2:0];
                    if (v[pplc_pkg::CTRL_TRIGGER] && !ctrl_next[port][pplc_pkg::CTRL_TRIGGER])
                    begin
                        if (cfg.multitap[port] && v[pplc_pkg::CTRL_MODE])
                        begin
                            tap_next[port] = 3'd0;
                        end
                        pend_next[port] = (cfg.delay != 11'd0) ? cfg.delay : 11'd1;
                    end
                    ctrl_next[port] = v;
                end
            end
            pplc_pkg::OP_LOAD:
            begin
                if (load_ok)
                begin
                    dval_next[req.device_index[pplc_pkg::DEV_AW-1:0]] = 1'b1;
                end
            end
            pplc_pkg::OP_TIME:
            begin
            end
            default:
            begin
            end
        endcase

        info.irq = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NP; p++)
            begin
                ctrl_reg[p] <= 3'd0;
                tap_reg[p]  <= 3'd0;
                pend_reg[p] <= 11'd0;
            end
            ready_reg       <= '0;
            irq_reg         <= 1'b0;
            dval_reg        <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
            if (accept)
            begin
                ctrl_reg  <= ctrl_next;
                tap_reg   <= tap_next;
                pend_reg  <= pend_next;
                ready_reg <= ready_next;
                irq_reg   <= irq_next;
                dval_reg  <= dval_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= info;
        end
    end

    assign ram_we      = accept && (req.op == pplc_pkg::OP_LOAD) && load_ok;
    assign ram_waddr   = req.device_index[pplc_pkg::DEV_AW-1:0];
    assign ram_wdata   = req.device_word;
    assign ram_raddr0  = slot[0][pplc_pkg::DEV_AW-1:0];
    assign ram_raddr1  = slot[1][pplc_pkg::DEV_AW-1:0];
    assign stage       = stage_reg;
    assign stage_valid = stage_valid_reg;

endmodule

// ===== hw/rtl/pplc_result.sv =====
// Result stage: latch words from the device table, form read data, queue results.
module pplc_result (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pplc_pkg::stage_t            stage,
    input  logic                        stage_valid,
    input  pplc_pkg::cfg_t              cfg,
    input  logic [pplc_pkg::WORD_W-1:0] ram_rdata0,
    input  logic [pplc_pkg::WORD_W-1:0] ram_rdata1,
    output pplc_pkg::rsp_t              rsp,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [1:0]                  count
);

    localparam int NP = pplc_pkg::NUM_PORTS;

    logic [pplc_pkg::WORD_W-1:0] latched_reg [NP];
    logic [pplc_pkg::WORD_W-1:0] word_next   [NP];
    logic [pplc_pkg::WORD_W-1:0] ram_rdata   [NP];
    pplc_pkg::rsp_t              q_reg       [2];
    pplc_pkg::rsp_t              q_next      [2];
    logic [1:0]                  count_reg;
    logic [1:0]                  count_next;
    pplc_pkg::rsp_t              result;
    logic                        pop;

    assign ram_rdata[0] = ram_rdata0;
    assign ram_rdata[1] = ram_rdata1;

    always_comb
    begin
        logic [pplc_pkg::WORD_W-1:0] word;
        logic [pplc_pkg::HALF_W-1:0] r;

        for (int p = 0; p < NP; p++)
        begin
            if (stage.latch[p])
            begin
                if (stage.use_sig[p])
                begin
                    word_next[p] = {cfg.tap_sig, 28'd0};
                end
                else
                begin
                    word_next[p] = stage.slot_ok[p] ? ram_rdata[p] : '0;
                end
            end
            else
            begin
                word_next[p] = latched_reg[p];
            end
        end

        word = word_next[stage.rd_port];
        if (stage.is_status)
        begin
            r = stage.status_set ? pplc_pkg::STATUS_READY : '0;
        end
        else
        begin
            r = stage.rd_high ? word[31:16] : word[15:0];
        end
        if (stage.byte_access)
        begin
            r = stage.byte_hi ? {8'd0, r[15:8]} : {8'd0, r[7:0]};
        end
        result.read_data = stage.is_read ? r : '0;
        result.irq       = stage.irq;
    end

    // Two-word output queue; entry 0 is the head.
    assign pop = rsp_valid && rsp_ready;

    always_comb
    begin
        logic [1:0] left;

        q_next = q_reg;
        left   = count_reg - {1'b0, pop};
        if (pop)
        begin
            q_next[0] = q_reg[1];
        end
        if (stage_valid)
        begin
            if (left == 2'd0)
            begin
                q_next[0] = result;
            end
            else
            begin
                q_next[1] = result;
            end
        end
        count_next = left + {1'b0, stage_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NP; p++)
            begin
                latched_reg[p] <= '0;
            end
            count_reg <= 2'd0;
        end
        else
        begin
            if (stage_valid)
            begin
                latched_reg <= word_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign rsp       = q_reg[0];
    assign rsp_valid = (count_reg != 2'd0);
    assign count     = count_reg;

endmodule

// ===== hw/rtl/pad_port_latch_controller.sv =====
// Top level of the pad port latch controller.
// Two-port pad interface behind registers. Each request word first advances
// time by its elapsed count: a port with a pending transfer counts down, and
// on expiry latches a 32-bit word (its own device, the multitap slot map, or
// the tap signature once the slots are used up), sets its ready flag, clears
// its trigger bit and raises irq. Then the request reads status or a data
// half, writes the three control bits, or loads a device table slot. Every
// request word yields exactly one response word. One request is taken per
// cycle while the output queue has room; an accepted request is registered
// in the port stage, and its response then enters the output queue from the
// result stage. Port state lives in flip-flops and is updated at acceptance;
// the device table is a RAM with two registered read ports, one per port, so
// both ports can latch in the same request and the latched words are formed
// in the cycle after. A two-word output queue keeps requests flowing while a
// response waits. The configuration channel is always ready and must only be
// written while no request is in flight.
module pad_port_latch_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pplc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pplc_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [10:0]    cfg_data
);

    pplc_pkg::cfg_t   cfg_reg;
    pplc_pkg::stage_t stage;
    logic             stage_valid;
    logic             accept;
    logic [1:0]       count;
    logic [2:0]       held;

    logic                        ram_we;
    logic [pplc_pkg::DEV_AW-1:0] ram_waddr;
    logic [pplc_pkg::WORD_W-1:0] ram_wdata;
    logic [pplc_pkg::DEV_AW-1:0] ram_raddr0;
    logic [pplc_pkg::DEV_AW-1:0] ram_raddr1;
    logic [pplc_pkg::WORD_W-1:0] ram_rdata0;
    logic [pplc_pkg::WORD_W-1:0] ram_rdata1;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.multitap <= pplc_pkg::MULTITAP_RESET;
            cfg_reg.tap_sig  <= pplc_pkg::SIG_RESET;
            cfg_reg.delay    <= pplc_pkg::DELAY_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pplc_pkg::CFG_MULTITAP: cfg_reg.multitap <= cfg_data[1:0];
                pplc_pkg::CFG_TAP_SIG:  cfg_reg.tap_sig  <= cfg_data[3:0];
                pplc_pkg::CFG_DELAY:    cfg_reg.delay    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Take a request only when the queue will have room for its response,
    // counting the one still in the result stage and the word leaving now.
    assign held      = {1'b0, count} + {2'd0, stage_valid} - {2'd0, rsp_valid && rsp_ready};
    assign req_ready = (held <= 3'd1);
    assign accept    = req_valid && req_ready;

    pplc_port_ctrl u_port_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req         (req),
        .cfg         (cfg_reg),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr0  (ram_raddr0),
        .ram_raddr1  (ram_raddr1),
        .stage       (stage),
        .stage_valid (stage_valid)
    );

    // Device table; reads return the old word when a load hits the same slot.
    pplc_ram #(
        .WIDTH (pplc_pkg::WORD_W),
        .DEPTH (pplc_pkg::NUM_DEVICES)
    ) u_dev_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr0),
        .raddr_b (ram_raddr1),
        .rdata_a (ram_rdata0),
        .rdata_b (ram_rdata1)
    );

    pplc_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .stage_valid (stage_valid),
        .cfg         (cfg_reg),
        .ram_rdata0  (ram_rdata0),
        .ram_rdata1  (ram_rdata1),
        .rsp         (rsp),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .count       (count)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the pad port latch controller.
module tb;

    // Cycles without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT = 4000;

    // Device slot picked by each tap position: [port][position].
    localparam logic [1:0][3:0][2:0] TAP_SLOT_MAP =
        {3'd7, 3'd6, 3'd5, 3'd1, 3'd4, 3'd3, 3'd2, 3'd0};

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    pplc_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    pplc_pkg::rsp_t rsp;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [10:0]    cfg_data;

    // Expected response words, oldest first.
    pplc_pkg::rsp_t pad_replies_q[$];

    // Own copy of the controller: registers and per-port state.
    logic [1:0]  mt_en_m;
    logic [3:0]  tap_sig_m;
    logic [10:0] delay_m;
    logic [2:0]  ctl_m   [2];
    logic [2:0]  taps_m  [2];
    logic        ready_m [2];
    logic [10:0] pend_m  [2];
    logic [31:0] latch_m [2];
    logic [31:0] dev_m   [8];
    logic        irq_m;

    int mismatch_count = 0;
    int word_count     = 0;
    int quiet_cycles   = 0;
    int rsp_hold       = 0;
    int phase_delay    = 1536;
    bit gaps_on        = 1'b1;
    bit rsp_stall_on   = 1'b1;

    pad_port_latch_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the response word for one accepted request word and advance
    // the model state: time first (port 0 before port 1), then the access.
    function automatic pplc_pkg::rsp_t predict_pad_item(input pplc_pkg::req_t w);
        pplc_pkg::rsp_t r;
        logic           pt;
        logic [15:0]    v;
        logic [15:0]    rd;
        logic [2:0]     slot;
        rd = '0;
        for (int p = 0; p < 2; p++)
        begin
            if (pend_m[p] != '0)
            begin
                if (w.elapsed < {5'd0, pend_m[p]})
                    pend_m[p] = pend_m[p] - w.elapsed[10:0];
                else
                begin
                    // Delay expired: latch the word and flag it.
                    pend_m[p] = '0;
                    if (mt_en_m[p])
                    begin
                        if (taps_m[p] >= pplc_pkg::TAP_SLOTS)
                            latch_m[p] = {tap_sig_m, 28'd0};
                        else
                        begin
                            slot = TAP_SLOT_MAP[p][taps_m[p][1:0]];
                            latch_m[p] = (slot < pplc_pkg::NUM_DEVICES) ? dev_m[slot] : '0;
                            taps_m[p]++;
                        end
                    end
                    else
                        latch_m[p] = dev_m[p];
                    ready_m[p] = 1'b1;
                    ctl_m[p][pplc_pkg::CTRL_TRIGGER] = 1'b0;
                    irq_m = 1'b1;
                end
            end
        end
        case (w.op)
            pplc_pkg::OP_READ:
            begin
                pt = w.address[pplc_pkg::ADDR_PORT];
                if (!w.address[pplc_pkg::ADDR_DEC] && !w.address[pplc_pkg::ADDR_HIGH])
                    rd = ready_m[pt] ? pplc_pkg::STATUS_READY : '0;
                else if (w.address[pplc_pkg::ADDR_HIGH])
                    rd = latch_m[pt][31:16];
                else
                begin
                    // Low half read hands the word over: drop ready.
                    rd = latch_m[pt][15:0];
                    ready_m[pt] = 1'b0;
                end
                if (!ready_m[0] && !ready_m[1])
                    irq_m = 1'b0;
                if (w.byte_access)
                    rd = w.address[pplc_pkg::ADDR_BYTE] ? {8'd0, rd[15:8]} : {8'd0, rd[7:0]};
            end
            pplc_pkg::OP_WRITE:
            begin
                v = w.byte_access ? {8'd0, w.write_data[7:0]} : w.write_data;
                if (!w.address[pplc_pkg::ADDR_DEC])
                begin
                    pt = w.address[pplc_pkg::ADDR_PORT];
                    if (v[pplc_pkg::CTRL_TRIGGER] && !ctl_m[pt][pplc_pkg::CTRL_TRIGGER])
                    begin
                        if (mt_en_m[pt] && v[pplc_pkg::CTRL_MODE])
                            taps_m[pt] = '0;
                        pend_m[pt] = (delay_m != '0) ? delay_m : 11'd1;
                    end
                    ctl_m[pt] = v[2:0];
                end
            end
            pplc_pkg::OP_LOAD:
            begin
                if (w.device_index < pplc_pkg::NUM_DEVICES)
                    dev_m[w.device_index] = w.device_word;
            end
            default: ;
        endcase
        r.read_data = rd;
        r.irq       = irq_m;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Sample all handshakes at the rising edge. Check the response before
    // queueing a new expectation: a response can never belong to the word
    // accepted at the same edge.
    always @(posedge clk)
    begin
        pplc_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pad_replies_q.size() == 0)
                    report_mismatch($sformatf("unexpected response word %h", rsp));
                else
                begin
                    want = pad_replies_q.pop_front();
                    if (rsp.read_data !== want.read_data)
                        report_mismatch($sformatf("read_data got %h expected %h",
                                                  rsp.read_data, want.read_data));
                    if (rsp.irq !== want.irq)
                        report_mismatch($sformatf("irq got %b expected %b",
                                                  rsp.irq, want.irq));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pplc_pkg::CFG_MULTITAP: mt_en_m   = cfg_data[1:0];
                    pplc_pkg::CFG_TAP_SIG:  tap_sig_m = cfg_data[3:0];
                    pplc_pkg::CFG_DELAY:    delay_m   = cfg_data;
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
                pad_replies_q.push_back(predict_pad_item(req));
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Elapsed counts sized to the current delay, so countdowns run over
    // several words; now and then a full-range jump.
    function automatic logic [15:0] pick_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 16'($urandom_range(0, 3));
        if (r < 88)
            return 16'($urandom_range(0, phase_delay / 2 + 1));
        return 16'($urandom);
    endfunction

    function automatic pplc_pkg::req_t rand_word();
        pplc_pkg::req_t w;
        w.op           = pplc_pkg::op_t'($urandom_range(0, 3));
        w.address      = 8'($urandom);
        w.byte_access  = 1'($urandom);
        w.write_data   = 16'($urandom);
        w.elapsed      = pick_elapsed();
        w.device_index = 3'($urandom);
        w.device_word  = $urandom;
        return w;
    endfunction

    function automatic pplc_pkg::req_t make_word(input pplc_pkg::op_t op,
                                                 input logic [7:0] addr,
                                                 input logic byte_acc,
                                                 input logic [15:0] wdata,
                                                 input logic [15:0] el,
                                                 input logic [2:0] idx,
                                                 input logic [31:0] dword);
        pplc_pkg::req_t w;
        w.op           = op;
        w.address      = addr;
        w.byte_access  = byte_acc;
        w.write_data   = wdata;
        w.elapsed      = el;
        w.device_index = idx;
        w.device_word  = dword;
        return w;
    endfunction

    // Response side: hold ready low for random stretches when stalls are on.
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (rsp_stall_on && $urandom_range(0, 99) < 20)
                    rsp_hold = pick_gap_len();
            end
        end
    end

    // Present one request word and hold it until accepted. Valid only drops
    // when a gap is taken, so it never falls and rises in one step.
    task automatic send_pad_word(input pplc_pkg::req_t w);
        int gap;
        gap = (gaps_on && $urandom_range(0, 99) < 30) ? pick_gap_len() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        word_count++;
    endtask

    // Stop sending and wait for every expected word plus the pipeline depth.
    task automatic drain_and_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pad_replies_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg_reg(input logic [1:0] idx, input logic [10:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Everything reads as zero out of reset.
    task automatic test_reset_values();
        send_pad_word(make_word(pplc_pkg::OP_READ, 8'h00, 1'b0, 16'h0000, 16'd0, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_READ, 8'hC3, 1'b1, 16'h0000, 16'd0, 3'd7,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_TIME, 8'hFF, 1'b0, 16'hFFFF, 16'hFFFF, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_READ, 8'h40, 1'b0, 16'h0000, 16'd0, 3'd0,
                                32'd0));
    endtask

    // Latch on both ports at the reset delay: countdown edge, status, both
    // halves, byte selects, ignored addresses, re-trigger without a rising
    // edge, and both ports expiring in one word.
    task automatic test_port_latch();
        send_pad_word(make_word(pplc_pkg::OP_LOAD, 8'h00, 1'b0, 16'h0000, 16'd0, 3'd0,
                                32'hFFFF_FFFF));
        send_pad_word(make_word(pplc_pkg::OP_LOAD, 8'h00, 1'b0, 16'h0000, 16'd0, 3'd1,
                                32'h8000_0001));
        // Byte write: upper byte of the data is dropped.
        send_pad_word(make_word(pplc_pkg::OP_WRITE, 8'h00, 1'b1, 16'hFFF9, 16'd0, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_TIME, 8'h00, 1'b0, 16'h0000, 16'd1535, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_READ, 8'h00, 1'b0, 16'h0000, 16'd0, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_WRITE, 8'h80, 1'b0, 16'h0007, 16'd1, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_READ, 8'h3C, 1'b1, 16'h0000, 16'd0, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_READ, 8'h02, 1'b0, 16'h0000, 16'd0, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_WRITE, 8'h00, 1'b0, 16'h0001, 16'd0, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_READ, 8'h41, 1'b1, 16'h0000, 16'd0, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_WRITE, 8'h40, 1'b0, 16'hFFFF, 16'hFFFF, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_WRITE, 8'h80, 1'b0, 16'h0001, 16'd0, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_WRITE, 8'h80, 1'b0, 16'h0001, 16'd2, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_READ, 8'h82, 1'b0, 16'h0000, 16'd0, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_READ, 8'hC0, 1'b0, 16'h0000, 16'd0, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_READ, 8'h40, 1'b0, 16'h0000, 16'd0, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_TIME, 8'h00, 1'b0, 16'h0000, 16'hFFFF, 3'd0,
                                32'd0));
    endtask

    // Multitap on port 1 with a zero delay (counts as one): clear the tap
    // count, walk all four slots, then the signature once they run out.
    task automatic test_tap_signature();
        drain_and_idle();
        write_cfg_reg(pplc_pkg::CFG_MULTITAP, 11'h557);
        write_cfg_reg(pplc_pkg::CFG_TAP_SIG, 11'h7FF);
        write_cfg_reg(pplc_pkg::CFG_DELAY, 11'd0);
        send_pad_word(make_word(pplc_pkg::OP_WRITE, 8'h80, 1'b0, 16'h0000, 16'd0, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_WRITE, 8'h80, 1'b0, 16'h0003, 16'd0, 3'd0,
                                32'd0));
        repeat (4)
            send_pad_word(make_word(pplc_pkg::OP_WRITE, 8'h80, 1'b0, 16'h0001, 16'd1, 3'd0,
                                    32'd0));
        send_pad_word(make_word(pplc_pkg::OP_READ, 8'h82, 1'b0, 16'h0000, 16'd1, 3'd0,
                                32'd0));
        send_pad_word(make_word(pplc_pkg::OP_READ, 8'hC0, 1'b0, 16'h0000, 16'd0, 3'd0,
                                32'd0));
    endtask

    // One full transfer on a random port with random content: maybe load a
    // device, arm (trigger low, then rising), let time pass with status
    // polls, then collect status, high half and low half.
    task automatic run_port_sequence();
        pplc_pkg::req_t w;
        logic           pt;
        pt = 1'($urandom);
        if ($urandom_range(0, 2) == 0)
        begin
            w    = rand_word();
            w.op = pplc_pkg::OP_LOAD;
            send_pad_word(w);
        end
        w    = rand_word();
        w.op = pplc_pkg::OP_WRITE;
        w.address[pplc_pkg::ADDR_PORT]       = pt;
        w.address[pplc_pkg::ADDR_DEC]        = 1'b0;
        w.write_data[pplc_pkg::CTRL_TRIGGER] = 1'b0;
        send_pad_word(w);
        w.write_data = 16'($urandom);
        w.write_data[pplc_pkg::CTRL_TRIGGER] = 1'b1;
        w.elapsed    = pick_elapsed();
        w.byte_access = 1'($urandom);
        send_pad_word(w);
        repeat ($urandom_range(0, 4))
        begin
            w    = rand_word();
            w.op = ($urandom_range(0, 1) != 0) ? pplc_pkg::OP_TIME : pplc_pkg::OP_READ;
            w.address[pplc_pkg::ADDR_PORT] = pt;
            w.address[pplc_pkg::ADDR_DEC]  = 1'b0;
            w.address[pplc_pkg::ADDR_HIGH] = 1'b0;
            send_pad_word(w);
        end
        w    = rand_word();
        w.op = pplc_pkg::OP_READ;
        w.address[pplc_pkg::ADDR_PORT] = pt;
        w.address[pplc_pkg::ADDR_DEC]  = 1'b0;
        w.address[pplc_pkg::ADDR_HIGH] = 1'b0;
        send_pad_word(w);
        w    = rand_word();
        w.op = pplc_pkg::OP_READ;
        w.address[pplc_pkg::ADDR_PORT] = pt;
        w.address[pplc_pkg::ADDR_HIGH] = 1'b1;
        send_pad_word(w);
        w    = rand_word();
        w.op = pplc_pkg::OP_READ;
        w.address[pplc_pkg::ADDR_PORT] = pt;
        w.address[pplc_pkg::ADDR_DEC]  = 1'b1;
        w.address[pplc_pkg::ADDR_HIGH] = 1'b0;
        send_pad_word(w);
    endtask

    // Phases with different register settings, extremes included. Each
    // phase starts from an idle block; idling on either side varies by phase.
    task automatic test_random_traffic();
        logic [1:0]  mt;
        logic [3:0]  sig;
        logic [10:0] dly;
        int          stop_at;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin mt = 2'd0; sig = 4'd0;  dly = 11'd2047; end
                1: begin mt = 2'd3; sig = 4'd15; dly = 11'd1;    end
                2: begin mt = 2'd1; sig = 4'd5;  dly = 11'd3;    end
                3: begin mt = 2'd2; sig = 4'd9;  dly = 11'd40;   end
                4: begin mt = 2'd3; sig = 4'd0;  dly = 11'd12;   end
                5: begin mt = 2'd0; sig = 4'd14; dly = 11'd1536; end
                6: begin mt = 2'd3; sig = 4'd7;  dly = 11'd2;    end
                default:
                begin
                    mt  = 2'($urandom);
                    sig = 4'($urandom);
                    dly = 11'($urandom_range(1, 64));
                end
            endcase
            drain_and_idle();
            write_cfg_reg(pplc_pkg::CFG_MULTITAP, {9'($urandom), mt});
            write_cfg_reg(pplc_pkg::CFG_TAP_SIG, {7'($urandom), sig});
            write_cfg_reg(pplc_pkg::CFG_DELAY, dly);
            phase_delay  = (dly == '0) ? 1 : int'(dly);
            gaps_on      = (ph % 3 != 0) && (ph != 4);
            rsp_stall_on = (ph % 4 != 1) && (ph != 4);
            stop_at      = word_count + 150;
            while (word_count < stop_at)
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) send_pad_word(rand_word());
                else
                    run_port_sequence();
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = pplc_pkg::CFG_MULTITAP;
        cfg_data  = '0;
        mt_en_m   = pplc_pkg::MULTITAP_RESET;
        tap_sig_m = pplc_pkg::SIG_RESET;
        delay_m   = pplc_pkg::DELAY_RESET;
        irq_m     = 1'b0;
        for (int p = 0; p < 2; p++)
        begin
            ctl_m[p]   = '0;
            taps_m[p]  = '0;
            ready_m[p] = 1'b0;
            pend_m[p]  = '0;
            latch_m[p] = '0;
        end
        for (int d = 0; d < 8; d++)
            dev_m[d] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_port_latch();
        test_tap_signature();
        test_random_traffic();

        // Drain, then give the pipeline time to show any stray word.
        drain_and_idle();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pplc_pkg.sv
hw/rtl/pplc_ram.sv
hw/rtl/pplc_port_ctrl.sv
hw/rtl/pplc_result.sv
hw/rtl/pad_port_latch_controller.sv
tb/tb.sv
